// ===== sv/mls_pkg.sv =====
// shared types, constants and codes of the mesh laplacian stencil
`default_nettype none

package mls_pkg;

   localparam int MESH_CELLS = 4096;
   localparam int ADDR_W     = $clog2(MESH_CELLS);
   localparam int IDX_W      = 12;
   localparam int SIZE_W     = 13;
   localparam int INV_W      = 48;
   localparam int VAL_W      = 32;
   localparam int LAP_W      = 64;
   localparam int TOT_W      = 3 * SIZE_W;
   localparam int DIFF_W     = 40;
   localparam int CHUNK_W    = 16;
   localparam int CHUNKS     = INV_W / CHUNK_W;
   localparam int PP_W       = DIFF_W + CHUNK_W;
   localparam int PROD_W     = DIFF_W + INV_W;
   localparam int ACC_W      = 96;
   localparam int CSR_AW     = 6;
   localparam int CSR_DW     = 64;

   localparam logic [1:0] GEO_SPHERE   = 2'd0;
   localparam logic [1:0] GEO_CYLINDER = 2'd1;
   localparam logic [1:0] GEO_CUBOID   = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BOUNDARY = 2'd1;
   localparam logic [1:0] ST_OUTSIDE  = 2'd2;

   localparam logic [2:0] REG_GEOMETRY    = 3'd0;
   localparam logic [2:0] REG_SIZE_FIRST  = 3'd1;
   localparam logic [2:0] REG_SIZE_SECOND = 3'd2;
   localparam logic [2:0] REG_SIZE_THIRD  = 3'd3;
   localparam logic [2:0] REG_INV_FIRST   = 3'd4;
   localparam logic [2:0] REG_INV_SECOND  = 3'd5;
   localparam logic [2:0] REG_INV_THIRD   = 3'd6;

   typedef struct packed {
      logic                    command;
      logic [IDX_W-1:0]        cell_index;
      logic signed [VAL_W-1:0] cell_value;
   } req_type;

   typedef struct packed {
      logic signed [LAP_W-1:0] laplace_value;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        geometry;
      logic [SIZE_W-1:0] size_first;
      logic [SIZE_W-1:0] size_second;
      logic [SIZE_W-1:0] size_third;
      logic [INV_W-1:0]  inv_first;
      logic [INV_W-1:0]  inv_second;
      logic [INV_W-1:0]  inv_third;
   } cfg_type;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_NONE,
      OP_SPH_CTR,
      OP_SPH,
      OP_CYL_CTR,
      OP_CYL,
      OP_CUB
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [1:0]              status;
      logic [IDX_W-1:0]        idx;
      logic signed [VAL_W-1:0] value;
      logic [IDX_W-1:0]        radial;
      logic [SIZE_W-1:0]       far_stride;
      logic [SIZE_W-1:0]       mid_stride;
   } job_type;

endpackage

`default_nettype wire

// ===== sv/mls_front.sv =====
// front end: accepts items, checks range, splits the index and classifies the cell
`default_nettype none

module mls_front import mls_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push_valid,
   input  logic    push_ready,
   output job_type push_job
);

   typedef enum logic [2:0] {F_IDLE, F_TOTAL, F_CHECK, F_DIV, F_CLASS, F_PUSH} fstate_type;

   fstate_type              state_ff, state_in;
   logic                    cmd_ff, cmd_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [2*SIZE_W-1:0]     p1_ff, p1_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic [IDX_W-1:0]        dvd_ff, dvd_in;
   logic [IDX_W-1:0]        rem_ff, rem_in;
   logic [SIZE_W-1:0]       divisor_ff, divisor_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic                    pass_ff, pass_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   job_type                 job_ff, job_in;

   logic [SIZE_W-1:0]       trial;
   logic [IDX_W-1:0]        rem_nx;
   logic [IDX_W-1:0]        quo_nx;
   logic                    qbit;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      value_in   = value_ff;
      p1_in      = p1_ff;
      total_in   = total_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      pass_in    = pass_ff;
      k_in       = k_ff;
      job_in     = job_ff;
      trial      = {rem_ff, dvd_ff[IDX_W-1]};
      qbit       = (trial >= divisor_ff);
      rem_nx     = qbit ? IDX_W'(trial - divisor_ff) : trial[IDX_W-1:0];
      quo_nx     = {dvd_ff[IDX_W-2:0], qbit};
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.command;
               idx_in   = req_data.cell_index;
               value_in = req_data.cell_value;
               if (cfg.geometry == GEO_CYLINDER) begin
                  p1_in = (2*SIZE_W)'(cfg.size_first) * (2*SIZE_W)'(cfg.size_second);
               end else begin
                  p1_in = (2*SIZE_W)'(cfg.size_second) * (2*SIZE_W)'(cfg.size_third);
               end
               state_in = F_TOTAL;
            end
         end
         F_TOTAL: begin
            case (cfg.geometry)
               GEO_SPHERE:   total_in = TOT_W'(cfg.size_first);
               GEO_CYLINDER: total_in = TOT_W'(p1_ff);
               default:      total_in = TOT_W'(cfg.size_first) * TOT_W'(p1_ff);
            endcase
            state_in = F_CHECK;
         end
         F_CHECK: begin
            job_in.op         = OP_NONE;
            job_in.status     = ST_OK;
            job_in.idx        = idx_ff;
            job_in.value      = value_ff;
            job_in.radial     = '0;
            job_in.far_stride = '0;
            job_in.mid_stride = '0;
            state_in          = F_PUSH;
            if (total_ff > TOT_W'(MESH_CELLS) || TOT_W'(idx_ff) >= total_ff) begin
               job_in.status = ST_OUTSIDE;
            end else if (!cmd_ff) begin
               job_in.op = OP_WRITE;
            end else if (cfg.geometry == GEO_SPHERE) begin
               if (SIZE_W'(idx_ff) == cfg.size_first - SIZE_W'(1)) begin
                  job_in.status = ST_BOUNDARY;
               end else if (idx_ff == '0) begin
                  job_in.op = OP_SPH_CTR;
               end else begin
                  job_in.op     = OP_SPH;
                  job_in.radial = idx_ff;
               end
            end else begin
               dvd_in     = idx_ff;
               rem_in     = '0;
               cnt_in     = '0;
               pass_in    = 1'b0;
               divisor_in = (cfg.geometry == GEO_CYLINDER) ? cfg.size_second : cfg.size_third;
               state_in   = F_DIV;
            end
         end
         F_DIV: begin
            rem_in = rem_nx;
            dvd_in = quo_nx;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(IDX_W-1)) begin
               if (!pass_ff && cfg.geometry != GEO_CYLINDER) begin
                  k_in       = rem_nx;
                  rem_in     = '0;
                  cnt_in     = '0;
                  pass_in    = 1'b1;
                  divisor_in = cfg.size_second;
               end else begin
                  state_in = F_CLASS;
               end
            end
         end
         F_CLASS: begin
            state_in = F_PUSH;
            if (cfg.geometry == GEO_CYLINDER) begin
               job_in.far_stride = cfg.size_second;
               if (rem_ff == '0 || SIZE_W'(rem_ff) == cfg.size_second - SIZE_W'(1) ||
                   SIZE_W'(dvd_ff) == cfg.size_first - SIZE_W'(1)) begin
                  job_in.status = ST_BOUNDARY;
               end else if (dvd_ff == '0) begin
                  job_in.op = OP_CYL_CTR;
               end else begin
                  job_in.op     = OP_CYL;
                  job_in.radial = dvd_ff;
               end
            end else begin
               if (dvd_ff == '0 || rem_ff == '0 || k_ff == '0 ||
                   SIZE_W'(dvd_ff) == cfg.size_first - SIZE_W'(1) ||
                   SIZE_W'(rem_ff) == cfg.size_second - SIZE_W'(1) ||
                   SIZE_W'(k_ff) == cfg.size_third - SIZE_W'(1)) begin
                  job_in.status = ST_BOUNDARY;
               end else begin
                  job_in.op         = OP_CUB;
                  job_in.far_stride = p1_ff[SIZE_W-1:0];
                  job_in.mid_stride = cfg.size_third;
               end
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      value_ff   <= value_in;
      p1_ff      <= p1_in;
      total_ff   <= total_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
      pass_ff    <= pass_in;
      k_ff       <= k_in;
      job_ff     <= job_in;
   end

   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_job   = job_ff;

endmodule

`default_nettype wire

// ===== sv/mls_queue.sv =====
// two-entry job queue between front end and back end
`default_nettype none

module mls_queue import mls_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_job   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mls_back.sv =====
// back end: mesh memory, neighbor reads, multiply, polar divide, sum and saturation
`default_nettype none

module mls_back import mls_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {B_IDLE, B_READ, B_TERM, B_MUL, B_DIV, B_ADD, B_DONE} bstate_type;

   bstate_type              state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic signed [VAL_W-1:0] u_ff [7];
   logic signed [VAL_W-1:0] u_in [7];
   logic [1:0]              term_ff, term_in;
   logic [DIFF_W-1:0]       mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [INV_W-1:0]        fac_ff, fac_in;
   logic                    dodiv_ff, dodiv_in;
   logic [1:0]              pass_ff, pass_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [IDX_W-1:0]        rem_ff, rem_in;
   logic [6:0]              dcnt_ff, dcnt_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [VAL_W-1:0]        mem [MESH_CELLS];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    mem_we;
   logic [SIZE_W:0]         addr_wide;

   logic signed [DIFF_W-1:0] uc, ep, em, fp, fm, mp, mm;
   logic signed [DIFF_W-1:0] sd_e, sd_f, sd_m, d_e, d_f, dsel;
   logic [INV_W-1:0]         fsel;
   logic                     divsel;
   logic [1:0]               nterms;
   logic [CHUNK_W-1:0]       chunk;
   logic [PP_W-1:0]          pp;
   logic [PROD_W-1:0]        pp_shift;
   logic [IDX_W:0]           trial;
   logic                     qbit;
   logic [ACC_W-1:0]         term_val;
   logic [LAP_W-1:0]         sat_val;

   // neighbor address per read slot
   always_comb begin
      case (cnt_ff)
         3'd1:    addr_wide = (SIZE_W+1)'(job_ff.idx) + (SIZE_W+1)'(1);
         3'd2:    addr_wide = (SIZE_W+1)'(job_ff.idx) - (SIZE_W+1)'(1);
         3'd3:    addr_wide = (SIZE_W+1)'(job_ff.idx) + (SIZE_W+1)'(job_ff.far_stride);
         3'd4:    addr_wide = (SIZE_W+1)'(job_ff.idx) - (SIZE_W+1)'(job_ff.far_stride);
         3'd5:    addr_wide = (SIZE_W+1)'(job_ff.idx) + (SIZE_W+1)'(job_ff.mid_stride);
         3'd6:    addr_wide = (SIZE_W+1)'(job_ff.idx) - (SIZE_W+1)'(job_ff.mid_stride);
         default: addr_wide = (SIZE_W+1)'(job_ff.idx);
      endcase
      rd_addr = ADDR_W'(addr_wide);
   end

   assign mem_we = (state_ff == B_IDLE) && job_valid && (job.op == OP_WRITE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ADDR_W'(job.idx)] <= job.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // stencil term selection
   always_comb begin
      uc   = DIFF_W'(u_ff[0]);
      ep   = DIFF_W'(u_ff[1]);
      em   = DIFF_W'(u_ff[2]);
      fp   = DIFF_W'(u_ff[3]);
      fm   = DIFF_W'(u_ff[4]);
      mp   = DIFF_W'(u_ff[5]);
      mm   = DIFF_W'(u_ff[6]);
      sd_e = ep + em - (uc <<< 1);
      sd_f = fp + fm - (uc <<< 1);
      sd_m = mp + mm - (uc <<< 1);
      d_e  = ep - uc;
      d_f  = fp - uc;
      dsel   = '0;
      fsel   = cfg.inv_first;
      divsel = 1'b0;
      nterms = 2'd3;
      case (job_ff.op)
         OP_SPH_CTR: begin
            nterms = 2'd1;
            dsel   = d_e * 6;
         end
         OP_SPH: begin
            nterms = 2'd2;
            if (term_ff == 2'd0) begin
               dsel = sd_e;
            end else begin
               dsel   = d_e <<< 1;
               divsel = 1'b1;
            end
         end
         OP_CYL_CTR: begin
            nterms = 2'd2;
            if (term_ff == 2'd0) begin
               dsel = sd_e;
               fsel = cfg.inv_second;
            end else begin
               dsel = d_f <<< 2;
            end
         end
         OP_CYL: begin
            case (term_ff)
               2'd0: begin
                  dsel = sd_e;
                  fsel = cfg.inv_second;
               end
               2'd1: dsel = sd_f;
               default: begin
                  dsel   = d_f;
                  divsel = 1'b1;
               end
            endcase
         end
         OP_CUB: begin
            case (term_ff)
               2'd0: dsel = sd_f;
               2'd1: begin
                  dsel = sd_m;
                  fsel = cfg.inv_second;
               end
               default: begin
                  dsel = sd_e;
                  fsel = cfg.inv_third;
               end
            endcase
         end
         default: nterms = 2'd1;
      endcase
   end

   // datapath helpers
   always_comb begin
      case (pass_ff)
         2'd0:    chunk = fac_ff[CHUNK_W-1:0];
         2'd1:    chunk = fac_ff[2*CHUNK_W-1:CHUNK_W];
         default: chunk = fac_ff[3*CHUNK_W-1:2*CHUNK_W];
      endcase
      pp = PP_W'(mag_ff) * PP_W'(chunk);
      case (pass_ff)
         2'd0:    pp_shift = PROD_W'(pp);
         2'd1:    pp_shift = PROD_W'(pp) << CHUNK_W;
         default: pp_shift = PROD_W'(pp) << (2*CHUNK_W);
      endcase
      trial    = {rem_ff, prod_ff[PROD_W-1]};
      qbit     = (trial >= (IDX_W+1)'(job_ff.radial));
      term_val = neg_ff ? ACC_W'(-ACC_W'(prod_ff)) : ACC_W'(prod_ff);
      if (acc_ff[ACC_W-1:LAP_W-1] == '0 || acc_ff[ACC_W-1:LAP_W-1] == '1) begin
         sat_val = acc_ff[LAP_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_val = {1'b1, {(LAP_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(LAP_W-1){1'b1}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      cnt_in       = cnt_ff;
      u_in         = u_ff;
      term_in      = term_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      fac_in       = fac_ff;
      dodiv_in     = dodiv_ff;
      pass_in      = pass_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_in  = job;
               acc_in  = '0;
               cnt_in  = '0;
               term_in = '0;
               if (job.op inside {OP_WRITE, OP_NONE}) begin
                  state_in = B_DONE;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            if (cnt_ff != 3'd0) begin
               u_in[cnt_ff - 3'd1] = rd_data_ff;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = B_TERM;
            end
         end
         B_TERM: begin
            neg_in   = dsel[DIFF_W-1];
            mag_in   = dsel[DIFF_W-1] ? DIFF_W'(-dsel) : DIFF_W'(dsel);
            fac_in   = fsel;
            dodiv_in = divsel;
            prod_in  = '0;
            pass_in  = '0;
            state_in = B_MUL;
         end
         B_MUL: begin
            prod_in = prod_ff + pp_shift;
            pass_in = pass_ff + 2'd1;
            if (pass_ff == 2'(CHUNKS-1)) begin
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = dodiv_ff ? B_DIV : B_ADD;
            end
         end
         B_DIV: begin
            rem_in  = qbit ? IDX_W'(trial - (IDX_W+1)'(job_ff.radial)) : trial[IDX_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], qbit};
            dcnt_in = dcnt_ff + 7'd1;
            if (dcnt_ff == 7'(PROD_W-1)) begin
               state_in = B_ADD;
            end
         end
         B_ADD: begin
            acc_in  = acc_ff + term_val;
            term_in = term_ff + 2'd1;
            state_in = (term_ff == nterms - 2'd1) ? B_DONE : B_TERM;
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (job_ff.op inside {OP_WRITE, OP_NONE}) begin
                  rsp_data_in.laplace_value = '0;
                  rsp_data_in.status        = job_ff.status;
               end else begin
                  rsp_data_in.laplace_value = sat_val;
                  rsp_data_in.status        = ST_OK;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff      <= job_in;
      cnt_ff      <= cnt_in;
      u_ff        <= u_in;
      term_ff     <= term_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      fac_ff      <= fac_in;
      dodiv_ff    <= dodiv_in;
      pass_ff     <= pass_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign job_ready = (state_ff == B_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_OK |-> rsp_data_ff.laplace_value == '0)
      else $error("error beat carries a nonzero value");

   a_div_radial: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DIV |-> job_ff.radial != '0)
      else $error("polar divide by zero radial index");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_TERM |-> term_ff < nterms)
      else $error("stencil term index past last term");

endmodule

`default_nettype wire

// ===== sv/mesh_laplacian_stencil.sv =====
// top level: configuration registers, front end, job queue and back end
// A write item needs no index division; a query needs none for a sphere, one for a
// cylinder and two for a cuboid (12-step index divisions in the front end). The back end
// then reads the cell and six neighbor slots through the single mesh memory port. For
// each stencil term it multiplies in 16-bit chunks, and for the polar 1/i term it also
// divides by the radial index bit by bit; it then sums the terms with saturation. A
// result is held until rsp_ready takes it. A two-entry queue lets the front end classify
// the next item while the back end works. The mesh memory is not cleared: a cell must be
// written before a query reads it.
`default_nettype none

module mesh_laplacian_stencil import mls_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type    cfg_ff;
   logic [2:0] reg_sel;
   logic       push_valid, push_ready, pop_valid, pop_ready;
   job_type    push_job, pop_job;

   assign pready  = 1'b1;
   assign reg_sel = paddr[CSR_AW-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.geometry    <= GEO_CUBOID;
         cfg_ff.size_first  <= SIZE_W'(16);
         cfg_ff.size_second <= SIZE_W'(16);
         cfg_ff.size_third  <= SIZE_W'(16);
         cfg_ff.inv_first   <= INV_W'(1);
         cfg_ff.inv_second  <= INV_W'(1);
         cfg_ff.inv_third   <= INV_W'(1);
      end else if (psel && penable && pwrite && pready) begin
         case (reg_sel)
            REG_GEOMETRY:    cfg_ff.geometry    <= pwdata[1:0];
            REG_SIZE_FIRST:  cfg_ff.size_first  <= pwdata[SIZE_W-1:0];
            REG_SIZE_SECOND: cfg_ff.size_second <= pwdata[SIZE_W-1:0];
            REG_SIZE_THIRD:  cfg_ff.size_third  <= pwdata[SIZE_W-1:0];
            REG_INV_FIRST:   cfg_ff.inv_first   <= pwdata[INV_W-1:0];
            REG_INV_SECOND:  cfg_ff.inv_second  <= pwdata[INV_W-1:0];
            REG_INV_THIRD:   cfg_ff.inv_third   <= pwdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_GEOMETRY:    prdata = CSR_DW'(cfg_ff.geometry);
         REG_SIZE_FIRST:  prdata = CSR_DW'(cfg_ff.size_first);
         REG_SIZE_SECOND: prdata = CSR_DW'(cfg_ff.size_second);
         REG_SIZE_THIRD:  prdata = CSR_DW'(cfg_ff.size_third);
         REG_INV_FIRST:   prdata = CSR_DW'(cfg_ff.inv_first);
         REG_INV_SECOND:  prdata = CSR_DW'(cfg_ff.inv_second);
         REG_INV_THIRD:   prdata = CSR_DW'(cfg_ff.inv_third);
         default:         prdata = '0;
      endcase
   end

   mls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   mls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_job    (push_job),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_job   (pop_job)
   );

   mls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
